[rtl/core/motor_pwm_ramp_deadzone_assert.svh]
// ----------------------------------------------------------------------------
// motor_pwm_ramp_deadzone assertion macros
// same-cycle and next-cycle implication checks, compiled out by NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef MOTOR_PWM_RAMP_DEADZONE_ASSERT_SVH
`define MOTOR_PWM_RAMP_DEADZONE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MPRD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mprd assertion failed");

`define MPRD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mprd assertion failed");

`else

`define MPRD_ASSERT_SAME(label, clk, rstn, ante, cons)

`define MPRD_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[rtl/core/mprd_pkg.sv]
// ----------------------------------------------------------------------------
// mprd_pkg
// shared types, register indexes, direction codes and pin mapping
// ----------------------------------------------------------------------------
package mprd_pkg;

    localparam int DUTY_W   = 8;
    localparam int DIR_W    = 2;
    localparam int PINS_W   = 4;
    localparam int TARGET_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [DIR_W-1:0] DIR_HALT  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP  = 2'd2;

    localparam logic [CFG_DATA_W-1:0] DEADZONE_RST   = 8'd40;
    localparam logic [CFG_DATA_W-1:0] DUTY_LIMIT_RST = 8'd255;
    localparam logic [CFG_DATA_W-1:0] SLEW_STEP_RST  = 8'd1;

    localparam logic [PINS_W-1:0] PINS_STOP  = 4'h0;
    localparam logic [PINS_W-1:0] PINS_LEFT  = 4'h9;
    localparam logic [PINS_W-1:0] PINS_RIGHT = 4'h6;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] deadzone;
        logic [CFG_DATA_W-1:0] duty_limit;
        logic [CFG_DATA_W-1:0] slew_step;
    } cfg_t;

    typedef struct packed {
        logic [DIR_W-1:0]  dir;
        logic [DUTY_W-1:0] mag;
    } want_t;

    function automatic logic [PINS_W-1:0] pins_for(input logic [DIR_W-1:0] dir);
        logic [PINS_W-1:0] pins;
        case (dir)
            DIR_LEFT:  pins = PINS_LEFT;
            DIR_RIGHT: pins = PINS_RIGHT;
            default:   pins = PINS_STOP;
        endcase
        return pins;
    endfunction

endpackage

[rtl/core/motor_pwm_ramp_deadzone.sv]
// ----------------------------------------------------------------------------
// motor_pwm_ramp_deadzone
// flow: a beat taken on s_ sits in the input stage, then the result stage drives m_
// throughput: one beat per cycle while m_ready does not stall the result stage
// reset: aresetn low clears duty, direction and both stages; registers reload defaults
// ----------------------------------------------------------------------------
module motor_pwm_ramp_deadzone
    import mprd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [TARGET_W-1:0] s_target_drive,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DUTY_W-1:0]     m_duty,
    output logic [DIR_W-1:0]      m_direction,
    output logic [PINS_W-1:0]     m_bridge_pins
);

    cfg_t  cfg;
    want_t want;

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [TARGET_W-1:0] target_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [DUTY_W-1:0]   duty_out_reg;
    logic [DIR_W-1:0]    dir_out_reg;
    logic [PINS_W-1:0]   pins_out_reg;
    logic                advance;
    logic [DUTY_W-1:0]   duty_next;
    logic [DIR_W-1:0]    dir_next;

    assign cfg_ready = 1'b1;

    mprd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input stage
    assign advance       = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = s_valid ? 1'b1 : (in_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            target_reg <= s_target_drive;
        end
    end

    mprd_target_decode u_decode (
        .target_drive (target_reg),
        .cfg          (cfg),
        .want         (want)
    );

    mprd_ramp u_ramp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update    (advance),
        .want      (want),
        .cfg       (cfg),
        .duty_next (duty_next),
        .dir_next  (dir_next)
    );

    // result stage
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            duty_out_reg <= duty_next;
            dir_out_reg  <= dir_next;
            pins_out_reg <= pins_for(dir_next);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_duty        = duty_out_reg;
    assign m_direction   = dir_out_reg;
    assign m_bridge_pins = pins_out_reg;

endmodule

[rtl/core/mprd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// mprd_cfg_regs
// deadzone, duty limit and ramp step registers with their write port
// ----------------------------------------------------------------------------
module mprd_cfg_regs
    import mprd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_DEADZONE:   cfg_next.deadzone   = cfg_data;
                CFG_DUTY_LIMIT: cfg_next.duty_limit = cfg_data;
                CFG_SLEW_STEP:  cfg_next.slew_step  = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deadzone   <= DEADZONE_RST;
            cfg_reg.duty_limit <= DUTY_LIMIT_RST;
            cfg_reg.slew_step  <= SLEW_STEP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/mprd_target_decode.sv]
// ----------------------------------------------------------------------------
// mprd_target_decode
// maps a signed target to wanted direction and clamped magnitude
// ----------------------------------------------------------------------------
module mprd_target_decode
    import mprd_pkg::*;
(
    input  logic [TARGET_W-1:0] target_drive,
    input  cfg_t                cfg,
    output want_t               want
);

    logic [TARGET_W:0] tgt_ext;
    logic [TARGET_W:0] mag;
    logic              is_neg;
    logic              is_pos;
    logic              in_dead;

    assign is_neg  = target_drive[TARGET_W-1];
    assign is_pos  = !is_neg && (target_drive != '0);
    assign tgt_ext = {is_neg, target_drive};
    // full-width magnitude so the most negative value stays positive
    assign mag     = is_neg ? ((TARGET_W+1)'(0) - tgt_ext) : tgt_ext;
    assign in_dead = mag < {{(TARGET_W+1-CFG_DATA_W){1'b0}}, cfg.deadzone};

    always_comb begin
        if (in_dead) begin
            want.dir = DIR_HALT;
            want.mag = '0;
        end else begin
            want.dir = is_pos ? DIR_LEFT : DIR_RIGHT;
            if (mag > {{(TARGET_W+1-CFG_DATA_W){1'b0}}, cfg.duty_limit}) begin
                want.mag = cfg.duty_limit;
            end else begin
                want.mag = mag[DUTY_W-1:0];
            end
        end
    end

endmodule

[rtl/core/mprd_ramp.sv]
// ----------------------------------------------------------------------------
// mprd_ramp
// present duty and direction state with slew-limited update
// ----------------------------------------------------------------------------
`include "motor_pwm_ramp_deadzone_assert.svh"

module mprd_ramp
    import mprd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              update,
    input  want_t             want,
    input  cfg_t              cfg,
    output logic [DUTY_W-1:0] duty_next,
    output logic [DIR_W-1:0]  dir_next
);

    logic [DUTY_W-1:0]       duty_reg;
    logic [DIR_W-1:0]        dir_reg;
    logic [DUTY_W-1:0]       duty_upd;
    logic [DIR_W-1:0]        dir_upd;
    logic [DUTY_W:0]         duty_sum;
    logic [DUTY_W-1:0]       duty_gap;
    logic                    dir_switch;
    logic [DUTY_W+DIR_W-1:0] state_cat;

    assign duty_sum = {1'b0, duty_reg} + {1'b0, cfg.slew_step};
    assign duty_gap = duty_reg - want.mag;

    always_comb begin
        duty_upd = duty_reg;
        dir_upd  = dir_reg;
        if (dir_reg != want.dir) begin
            // ramp down to zero before switching direction
            if (duty_reg != '0) begin
                duty_upd = (duty_reg > cfg.slew_step) ? (duty_reg - cfg.slew_step) : '0;
            end else begin
                dir_upd = want.dir;
            end
        end else if (duty_reg < want.mag) begin
            duty_upd = (duty_sum > {1'b0, want.mag}) ? want.mag : duty_sum[DUTY_W-1:0];
        end else if (duty_reg > want.mag) begin
            duty_upd = (duty_gap > cfg.slew_step) ? (duty_reg - cfg.slew_step) : want.mag;
        end
    end

    assign duty_next = update ? duty_upd : duty_reg;
    assign dir_next  = update ? dir_upd  : dir_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg <= '0;
            dir_reg  <= DIR_HALT;
        end else begin
            duty_reg <= duty_next;
            dir_reg  <= dir_next;
        end
    end

    assign dir_switch = update && (dir_upd != dir_reg);
    assign state_cat  = {duty_reg, dir_reg};

    `MPRD_ASSERT_SAME(a_dir_change_at_zero, aclk, aresetn, dir_switch, duty_reg == '0)
    `MPRD_ASSERT_SAME(a_dir_change_keeps_zero, aclk, aresetn, dir_switch, duty_upd == '0)
    `MPRD_ASSERT_SAME(a_no_overshoot, aclk, aresetn, update, (duty_upd <= duty_reg) || (duty_upd <= want.mag))
    `MPRD_ASSERT_SAME(a_reverse_ramps_down, aclk, aresetn, update && (dir_reg != want.dir), duty_upd <= duty_reg)
    `MPRD_ASSERT_NEXT(a_hold_when_idle, aclk, aresetn, !update, state_cat == $past(state_cat))

endmodule
